// ===== rtl/lrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared types and constants for the line row buffer with command check.
// ----------------------------------------------------------------------------
package lrb_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WIPE,
		ST_WRITE,
		ST_POP_RD,
		ST_POP_LD
	} state_t;

	localparam logic       KIND_STORE = 1'b0;
	localparam logic       KIND_POP   = 1'b1;

	localparam logic [7:0] CH_LINE_FEED = 8'h0A;
	localparam logic [7:0] DIGIT_BASE   = 8'h30;

	// command layout in row zero
	localparam int KEY_LEN     = 5;
	localparam int CODE_COL    = 5;
	localparam int DIGIT_FIRST = 6;
	localparam int DIGIT_LAST  = 9;

	// key prefix: ^1027
	function automatic logic [7:0] key_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h5E;
			3'd1:    ch = 8'h31;
			3'd2:    ch = 8'h30;
			3'd3:    ch = 8'h32;
			3'd4:    ch = 8'h37;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/lrb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read and write to the same address in one cycle returns the old data.
// ----------------------------------------------------------------------------
module lrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/line_row_buffer_with_command_check_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_row_buffer_with_command_check_unit
// Row buffer for received characters; pops emit row zero and flag a command.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser = kind (0 store rx_byte, 1 pop), tdata = rx_byte.
// A store writes the byte at the current row and column. The write position
// moves to the next row (with wrap) when the row is full or after a line feed;
// the new row is then wiped, and no request is taken during the wipe.
// A pop emits row zero on m_axis as ROW_BYTES bytes, tlast on the final one,
// which also carries the command report in tuser and the upper tdata bits.
// Each byte is a RAM read, then a load of the output register. A
// stalled receiver holds the output register and the pop waits on it.
// Rows live in one RAM addressed through a rotating head row, so a pop shifts
// the rows by moving the head; the popped row is zeroed as it is read out.
// After reset all ROW_COUNT * 2**clog2(ROW_BYTES) RAM words are swept to
// zero, with s_axis_tready low.
// ----------------------------------------------------------------------------
module line_row_buffer_with_command_check_unit
	import lrb_pkg::*;
#(
	parameter int ROW_COUNT = 8,
	parameter int ROW_BYTES = 34
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [15:8] command_code,
	                                    // [31:16] command_period
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // [0] command_valid
);

	localparam int RW    = $clog2(ROW_COUNT);
	localparam int CW    = $clog2(ROW_BYTES + 1);
	localparam int AC    = $clog2(ROW_BYTES);
	localparam int DEPTH = ROW_COUNT * (2 ** AC);
	localparam int AW    = $clog2(DEPTH);

	localparam logic [RW-1:0] ROW_LAST  = RW'(ROW_COUNT - 1);
	localparam logic [CW-1:0] COL_FULL  = CW'(ROW_BYTES);
	localparam logic [AC-1:0] COL_LAST  = AC'(ROW_BYTES - 1);
	localparam logic [AC-1:0] COL_KEY   = AC'(KEY_LEN);
	localparam logic [AC-1:0] COL_CODE  = AC'(CODE_COL);
	localparam logic [AC-1:0] COL_DIG0  = AC'(DIGIT_FIRST);
	localparam logic [AC-1:0] COL_DIG3  = AC'(DIGIT_LAST);
	localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

	state_t         state_q, state_d;
	logic [AW-1:0]  clr_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  head_q;
	logic [AC-1:0]  wipe_q;
	logic           pend_q;
	logic [7:0]     byte_q;
	logic [AC-1:0]  pc_q;
	logic           match_q;
	logic [7:0]     code_q;
	logic [15:0]    acc_q;

	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           out_last_q;
	logic           out_cmd_q;
	logic [7:0]     out_code_q;
	logic [15:0]    out_period_q;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [7:0]     ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	logic           load;
	logic           pc_last;
	logic [RW:0]    phys_sum;
	logic [RW-1:0]  wr_phys;
	logic [RW-1:0]  row_next;
	logic [RW-1:0]  head_next;
	logic [15:0]    acc_x10;
	logic [15:0]    digit;
	logic [15:0]    acc_next;

	// logical write row -> physical row
	assign phys_sum  = {1'b0, head_q} + {1'b0, row_q};
	assign wr_phys   = (phys_sum >= (RW + 1)'(ROW_COUNT)) ?
	                   RW'(phys_sum - (RW + 1)'(ROW_COUNT)) : RW'(phys_sum);
	assign row_next  = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
	assign head_next = (head_q == ROW_LAST) ? '0 : head_q + 1'b1;
	assign pc_last   = (pc_q == COL_LAST);
	assign acc_x10   = (acc_q << 3) + (acc_q << 1);
	assign digit     = {8'h00, ram_rdata} - {8'h00, DIGIT_BASE};
	// the last digit column may also be the last byte of the row
	assign acc_next  = (pc_q >= COL_DIG0 && pc_q <= COL_DIG3) ? acc_x10 + digit : acc_q;

	lrb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser == KIND_POP) state_d = ST_POP_RD;
					else if (col_q == COL_FULL) state_d = ST_WIPE;
					else state_d = ST_WRITE;
				end
			end
			ST_WIPE: begin
				if (wipe_q == COL_LAST) state_d = pend_q ? ST_WRITE : ST_IDLE;
			end
			ST_WRITE: begin
				state_d = (byte_q == CH_LINE_FEED) ? ST_WIPE : ST_IDLE;
			end
			ST_POP_RD: begin
				state_d = ST_POP_LD;
			end
			ST_POP_LD: begin
				if (load) state_d = pc_last ? ST_IDLE : ST_POP_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and RAM control
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = '0;
		ram_wdata     = '0;
		ram_re        = 1'b0;
		ram_raddr     = '0;
		load          = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_WIPE: begin
				ram_we    = 1'b1;
				ram_waddr = AW'({wr_phys, wipe_q});
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = AW'({wr_phys, col_q[AC-1:0]});
				ram_wdata = byte_q;
			end
			ST_POP_RD: begin
				// read the byte and zero it: this row becomes the bottom row
				ram_re    = 1'b1;
				ram_raddr = AW'({head_q, pc_q});
				ram_we    = 1'b1;
				ram_waddr = AW'({head_q, pc_q});
			end
			ST_POP_LD: begin
				load = !out_valid_q || m_axis_tready;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			head_q       <= '0;
			wipe_q       <= '0;
			pend_q       <= 1'b0;
			byte_q       <= '0;
			pc_q         <= '0;
			match_q      <= 1'b0;
			code_q       <= '0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b0;
			out_cmd_q    <= 1'b0;
			out_code_q   <= '0;
			out_period_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						byte_q  <= s_axis_tdata;
						pc_q    <= '0;
						match_q <= 1'b1;
						acc_q   <= '0;
						code_q  <= '0;
						if (s_axis_tuser == KIND_STORE && col_q == COL_FULL) begin
							row_q  <= row_next;
							col_q  <= '0;
							wipe_q <= '0;
							pend_q <= 1'b1;
						end
					end
				end
				ST_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
				end
				ST_WRITE: begin
					if (byte_q == CH_LINE_FEED) begin
						row_q  <= row_next;
						col_q  <= '0;
						wipe_q <= '0;
						pend_q <= 1'b0;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_POP_LD: begin
					if (load) begin
						out_byte_q  <= ram_rdata;
						out_last_q  <= pc_last;
						out_cmd_q   <= pc_last && match_q;
						out_code_q  <= (pc_last && match_q) ? code_q : 8'h00;
						out_period_q <= (pc_last && match_q) ?
						                {acc_next[14:0], 1'b0} : 16'h0000;
						if (pc_q < COL_KEY) begin
							match_q <= match_q && (ram_rdata == key_char(pc_q[2:0]));
						end
						if (pc_q == COL_CODE) code_q <= ram_rdata;
						acc_q <= acc_next;
						pc_q <= pc_q + 1'b1;
						if (pc_last) begin
							head_q <= head_next;
							if (row_q != '0) row_q <= row_q - 1'b1;
						end
					end
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_period_q, out_code_q, out_byte_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_cmd_q;

endmodule
